[rtl/block_gram_schmidt_qr_macros.svh]
// Assertion macros used by the block Gram-Schmidt QR top level.
`ifndef BLOCK_GRAM_SCHMIDT_QR_MACROS_SVH
`define BLOCK_GRAM_SCHMIDT_QR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BGSQR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGSQR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bgsqr_pkg.sv]
// Package with the types, codes and constants of the block Gram-Schmidt QR unit.
package bgsqr_pkg;

   localparam int MATRIX_SIZE_DEF = 16;
   localparam int BLOCK_COLS_DEF  = 4;
   localparam int SQRT_STEPS      = 32;
   localparam int DIV_STEPS       = 48;

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

   typedef enum logic [1:0] {
      FUNC_WRITE_A = 2'd0,
      FUNC_RUN     = 2'd1,
      FUNC_READ_Q  = 2'd2,
      FUNC_READ_R  = 2'd3
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [3:0]        row;
      logic [3:0]        col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_CLEAR, ST_COL_START, ST_RND_START, ST_NEXT_RND,
      ST_DOT_ISSUE, ST_DOT_DRAIN, ST_DOT_WRITE,
      ST_SUB_ISSUE, ST_SUB_DRAIN, ST_SUB_WRITE,
      ST_SSQ_ISSUE, ST_SSQ_DRAIN, ST_SQRT_LOAD, ST_SQRT_RUN, ST_NRM_WRITE,
      ST_DIV_READ, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_WRITE,
      ST_COL_NEXT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      YSEL_QB,
      YSEL_R,
      YSEL_UNIT
   } ysel_type;

   // Control that travels with each operand pair through the multiply-accumulate pipe.
   typedef struct packed {
      logic     vld;
      logic     first;
      logic     neg;
      logic     ssq;
      ysel_type ysel;
   } mac_ctl_type;

endpackage

[rtl/block_gram_schmidt_qr.sv]
// Top level of the block classical Gram-Schmidt QR unit.
//
//  channel  direction  handshake              word
//  req      in         start high, busy low   func, row, col, value
//  rsp      out        rsp_valid for 1 cycle  read_value, status
//
// A load answers in the next cycle and keeps the unit free; a read of Q or R holds
// busy in its read state and answers from the registered response after it. After a
// synchronous reset and at the start of a run, R is cleared with busy high. A run then
// works column by column: dot products, projection updates and the sum of squares
// use the one multiply-accumulate pipe, a square root gives the norm, and the divider
// normalizes the column row by row. Results cannot stall.
`include "block_gram_schmidt_qr_macros.svh"

module block_gram_schmidt_qr #(
   parameter int MATRIX_SIZE = bgsqr_pkg::MATRIX_SIZE_DEF,
   parameter int BLOCK_COLS  = bgsqr_pkg::BLOCK_COLS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bgsqr_pkg::req_type req,
   output logic               busy,
   output logic               rsp_valid,
   output bgsqr_pkg::rsp_type rsp
);

   localparam int N     = MATRIX_SIZE;
   localparam int CELLS = N * N;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(N + 1);
   localparam int BW    = (BLOCK_COLS < N) ? BLOCK_COLS : N;

   localparam logic signed [63:0] ACC_LIM   = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] ACC_NLIM  = 64'shC000_0000_0000_0000;
   localparam logic signed [63:0] ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_MIN   = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] I32_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] I32_MIN   = 64'shFFFF_FFFF_8000_0000;

   bgsqr_pkg::state_type state_ff, state_in;

   logic [CW-1:0] c_ff, b_ff, klo_ff, khi_ff, k_ff, i_ff;
   logic          rnd_ff, sub_init_ff, flag_ff, init_ff;
   logic [AW-1:0] clr_ff;
   logic          rd_q_ff, rd_in_ff;

   bgsqr_pkg::mac_ctl_type issue, s1_ff, s2_ff;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;

   logic [63:0] sq_x_ff, sq_res_ff, sq_bit_ff;
   logic [5:0]  step_ff;
   logic [31:0] nrm_ff, nrm_sat;
   logic [47:0] dv_num_ff;
   logic [32:0] dv_rem_ff;
   logic        dv_neg_ff;

   logic               rsp_valid_ff;
   bgsqr_pkg::rsp_type rsp_ff;

   logic [AW-1:0]      qa_addr, qb_addr, r_addr, q_waddr, r_waddr;
   logic               q_we, r_we;
   logic signed [31:0] q_wdata, r_wdata, qa_rd, qb_rd, r_rd;

   logic accept, host_inside, pipe_empty, last_i, last_k, col_last;
   logic [AW-1:0] host_addr;

   // Address of element (row, column) in column-major layout.
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
                                                input logic [CW-1:0] row);
      return AW'(int'(col) * N + int'(row));
   endfunction

   // Round a Q32.32 value to Q16.16 and saturate to 32 bits.
   function automatic logic signed [31:0] rnd32(input logic signed [63:0] v);
      logic signed [63:0] vc, t, q;
      vc = v;
      if (vc > ACC_LIM) vc = ACC_LIM;
      if (vc < ACC_NLIM) vc = ACC_NLIM;
      t = vc + 64'sd32768;
      q = t >>> 16;
      if (q > I32_MAX) return 32'sh7FFF_FFFF;
      if (q < I32_MIN) return 32'sh8000_0000;
      return 32'(q);
   endfunction

   assign accept      = start && (state_ff == bgsqr_pkg::ST_IDLE);
   assign host_inside = (7'(req.row) < 7'(N)) && (7'(req.col) < 7'(N));
   assign host_addr   = AW'(int'(req.col) * N + int'(req.row));
   assign pipe_empty  = !s1_ff.vld && !s2_ff.vld;
   assign last_i      = (i_ff == CW'(N - 1));
   assign last_k      = (k_ff == khi_ff - CW'(1));
   assign col_last    = ((c_ff - b_ff) == CW'(BW - 1));
   assign nrm_sat     = (sq_res_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sq_res_ff[31:0];

   // Memories: Q in two mirrored copies for two reads a cycle, R in one.
   bgsqr_ram #(.WIDTH(32), .DEPTH(CELLS)) q_mem_a (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(qa_addr), .rd_data(qa_rd));

   bgsqr_ram #(.WIDTH(32), .DEPTH(CELLS)) q_mem_b (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(qb_addr), .rd_data(qb_rd));

   bgsqr_ram #(.WIDTH(32), .DEPTH(CELLS)) r_mem (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_addr(r_addr), .rd_data(r_rd));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgsqr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.func) inside
                  bgsqr_pkg::FUNC_RUN: state_in = bgsqr_pkg::ST_CLEAR;
                  bgsqr_pkg::FUNC_READ_Q, bgsqr_pkg::FUNC_READ_R:
                     state_in = bgsqr_pkg::ST_READ;
                  default: state_in = bgsqr_pkg::ST_IDLE;
               endcase
            end
         end
         bgsqr_pkg::ST_READ: state_in = bgsqr_pkg::ST_IDLE;
         bgsqr_pkg::ST_CLEAR: begin
            // The pass after reset only clears R; the one of a run goes on to factor.
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = init_ff ? bgsqr_pkg::ST_IDLE : bgsqr_pkg::ST_COL_START;
            end
         end
         bgsqr_pkg::ST_COL_START: state_in = bgsqr_pkg::ST_RND_START;
         bgsqr_pkg::ST_RND_START: begin
            state_in = (klo_ff < khi_ff) ? bgsqr_pkg::ST_DOT_ISSUE
                                         : bgsqr_pkg::ST_NEXT_RND;
         end
         bgsqr_pkg::ST_NEXT_RND: begin
            state_in = rnd_ff ? bgsqr_pkg::ST_SSQ_ISSUE : bgsqr_pkg::ST_RND_START;
         end
         bgsqr_pkg::ST_DOT_ISSUE: begin
            if (last_i) state_in = bgsqr_pkg::ST_DOT_DRAIN;
         end
         bgsqr_pkg::ST_DOT_DRAIN: begin
            if (pipe_empty) state_in = bgsqr_pkg::ST_DOT_WRITE;
         end
         bgsqr_pkg::ST_DOT_WRITE: begin
            state_in = last_k ? bgsqr_pkg::ST_SUB_ISSUE : bgsqr_pkg::ST_DOT_ISSUE;
         end
         bgsqr_pkg::ST_SUB_ISSUE: begin
            if (!sub_init_ff && last_k) state_in = bgsqr_pkg::ST_SUB_DRAIN;
         end
         bgsqr_pkg::ST_SUB_DRAIN: begin
            if (pipe_empty) state_in = bgsqr_pkg::ST_SUB_WRITE;
         end
         bgsqr_pkg::ST_SUB_WRITE: begin
            state_in = last_i ? bgsqr_pkg::ST_NEXT_RND : bgsqr_pkg::ST_SUB_ISSUE;
         end
         bgsqr_pkg::ST_SSQ_ISSUE: begin
            if (last_i) state_in = bgsqr_pkg::ST_SSQ_DRAIN;
         end
         bgsqr_pkg::ST_SSQ_DRAIN: begin
            if (pipe_empty) state_in = bgsqr_pkg::ST_SQRT_LOAD;
         end
         bgsqr_pkg::ST_SQRT_LOAD: state_in = bgsqr_pkg::ST_SQRT_RUN;
         bgsqr_pkg::ST_SQRT_RUN: begin
            if (step_ff == 6'(bgsqr_pkg::SQRT_STEPS - 1)) state_in = bgsqr_pkg::ST_NRM_WRITE;
         end
         bgsqr_pkg::ST_NRM_WRITE: begin
            state_in = (nrm_sat == '0) ? bgsqr_pkg::ST_COL_NEXT : bgsqr_pkg::ST_DIV_READ;
         end
         bgsqr_pkg::ST_DIV_READ: state_in = bgsqr_pkg::ST_DIV_LOAD;
         bgsqr_pkg::ST_DIV_LOAD: state_in = bgsqr_pkg::ST_DIV_RUN;
         bgsqr_pkg::ST_DIV_RUN: begin
            if (step_ff == 6'(bgsqr_pkg::DIV_STEPS - 1)) state_in = bgsqr_pkg::ST_DIV_WRITE;
         end
         bgsqr_pkg::ST_DIV_WRITE: begin
            state_in = last_i ? bgsqr_pkg::ST_COL_NEXT : bgsqr_pkg::ST_DIV_READ;
         end
         bgsqr_pkg::ST_COL_NEXT: begin
            state_in = (c_ff == CW'(N - 1)) ? bgsqr_pkg::ST_DONE
                                            : bgsqr_pkg::ST_COL_START;
         end
         bgsqr_pkg::ST_DONE: state_in = bgsqr_pkg::ST_IDLE;
         default: state_in = bgsqr_pkg::ST_IDLE;
      endcase
   end

   // Memory ports and pipe issue for the current state.
   always_comb begin
      logic [47:0]        q;
      logic signed [31:0] dv_out;
      q = dv_num_ff;
      if (dv_neg_ff) begin
         dv_out = (q >= 48'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
      end else begin
         dv_out = (q >= 48'h8000_0000) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end
      qa_addr = '0;
      qb_addr = '0;
      r_addr  = '0;
      q_we    = 1'b0;
      q_waddr = '0;
      q_wdata = '0;
      r_we    = 1'b0;
      r_waddr = '0;
      r_wdata = '0;
      issue   = '{vld: 1'b0, first: 1'b0, neg: 1'b0, ssq: 1'b0,
                  ysel: bgsqr_pkg::YSEL_QB};
      unique case (state_ff)
         bgsqr_pkg::ST_IDLE: begin
            qa_addr = host_addr;
            r_addr  = host_addr;
            if (accept && req.func == bgsqr_pkg::FUNC_WRITE_A && host_inside) begin
               q_we    = 1'b1;
               q_waddr = host_addr;
               q_wdata = req.value;
            end
         end
         bgsqr_pkg::ST_CLEAR: begin
            r_we    = 1'b1;
            r_waddr = clr_ff;
         end
         bgsqr_pkg::ST_DOT_ISSUE: begin
            qa_addr = cell_addr(k_ff, i_ff);
            qb_addr = cell_addr(c_ff, i_ff);
            issue   = '{vld: 1'b1, first: (i_ff == '0), neg: 1'b0, ssq: 1'b0,
                        ysel: bgsqr_pkg::YSEL_QB};
         end
         bgsqr_pkg::ST_DOT_WRITE: begin
            r_we    = 1'b1;
            r_waddr = cell_addr(c_ff, k_ff);
            r_wdata = rnd32(acc_ff);
         end
         bgsqr_pkg::ST_SUB_ISSUE: begin
            if (sub_init_ff) begin
               qa_addr = cell_addr(c_ff, i_ff);
               issue   = '{vld: 1'b1, first: 1'b1, neg: 1'b0, ssq: 1'b0,
                           ysel: bgsqr_pkg::YSEL_UNIT};
            end else begin
               qa_addr = cell_addr(k_ff, i_ff);
               r_addr  = cell_addr(c_ff, k_ff);
               issue   = '{vld: 1'b1, first: 1'b0, neg: 1'b1, ssq: 1'b0,
                           ysel: bgsqr_pkg::YSEL_R};
            end
         end
         bgsqr_pkg::ST_SUB_WRITE: begin
            q_we    = 1'b1;
            q_waddr = cell_addr(c_ff, i_ff);
            q_wdata = rnd32(acc_ff);
         end
         bgsqr_pkg::ST_SSQ_ISSUE: begin
            qa_addr = cell_addr(c_ff, i_ff);
            qb_addr = cell_addr(c_ff, i_ff);
            issue   = '{vld: 1'b1, first: (i_ff == '0), neg: 1'b0, ssq: 1'b1,
                        ysel: bgsqr_pkg::YSEL_QB};
         end
         bgsqr_pkg::ST_NRM_WRITE: begin
            r_we    = 1'b1;
            r_waddr = cell_addr(c_ff, c_ff);
            r_wdata = $signed(nrm_sat);
         end
         bgsqr_pkg::ST_DIV_READ: begin
            qa_addr = cell_addr(c_ff, i_ff);
         end
         bgsqr_pkg::ST_DIV_WRITE: begin
            q_we    = 1'b1;
            q_waddr = cell_addr(c_ff, i_ff);
            q_wdata = dv_out;
         end
         default: begin
         end
      endcase
   end

   // Multiplier operand and saturating accumulate.
   always_comb begin
      logic signed [31:0] y;
      logic signed [63:0] base, pe;
      logic signed [64:0] ssum;
      logic [64:0]        usum;
      case (s1_ff.ysel)
         bgsqr_pkg::YSEL_R:    y = r_rd;
         bgsqr_pkg::YSEL_UNIT: y = bgsqr_pkg::ONE_Q16;
         default:              y = qb_rd;
      endcase
      prod_in = 64'(qa_rd) * 64'(y);
      base = s2_ff.first ? 64'sd0 : acc_ff;
      pe   = s2_ff.neg ? -prod_ff : prod_ff;
      ssum = 65'(base) + 65'(pe);
      usum = {1'b0, base} + {1'b0, pe};
      if (s2_ff.ssq) begin
         acc_in = usum[64] ? ACC_MIN | ACC_MAX : $signed(usum[63:0]);
      end else if (ssum[64] != ssum[63]) begin
         acc_in = ssum[64] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = ssum[63:0];
      end
   end

   // Pipe, square root, divider, loop counters and response registers.
   always_ff @(posedge clock) begin
      logic [63:0] trial;
      logic [32:0] rem_sh;
      logic        qbit;
      logic [31:0] mag;
      trial  = sq_res_ff + sq_bit_ff;
      rem_sh = {dv_rem_ff[31:0], dv_num_ff[47]};
      qbit   = (rem_sh >= {1'b0, nrm_ff});
      mag    = qa_rd[31] ? 32'(-qa_rd) : qa_rd;

      prod_ff <= prod_in;
      if (s2_ff.vld) acc_ff <= acc_in;
      rsp_valid_ff <= 1'b0;

      if (reset) begin
         // R is cleared by a pass that starts when reset is released.
         state_ff     <= bgsqr_pkg::ST_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_ff    <= issue;
         s2_ff    <= s1_ff;
         case (state_ff) inside
            bgsqr_pkg::ST_IDLE: begin
               rd_q_ff  <= (req.func == bgsqr_pkg::FUNC_READ_Q);
               rd_in_ff <= host_inside;
               clr_ff   <= '0;
               c_ff     <= '0;
               b_ff     <= '0;
               if (accept && req.func == bgsqr_pkg::FUNC_RUN) flag_ff <= 1'b0;
               if (accept && req.func == bgsqr_pkg::FUNC_WRITE_A) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{read_value: '0, status: flag_ff};
               end
            end
            bgsqr_pkg::ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.status <= flag_ff;
               rsp_ff.read_value <= !rd_in_ff ? 32'sd0 : (rd_q_ff ? qa_rd : r_rd);
            end
            bgsqr_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(CELLS - 1)) init_ff <= 1'b0;
            end
            bgsqr_pkg::ST_COL_START: begin
               klo_ff <= '0;
               khi_ff <= b_ff;
               rnd_ff <= 1'b0;
            end
            bgsqr_pkg::ST_RND_START: begin
               k_ff <= klo_ff;
               i_ff <= '0;
            end
            bgsqr_pkg::ST_NEXT_RND: begin
               rnd_ff <= 1'b1;
               klo_ff <= b_ff;
               khi_ff <= c_ff;
               i_ff   <= '0;
            end
            bgsqr_pkg::ST_DOT_ISSUE, bgsqr_pkg::ST_SSQ_ISSUE: i_ff <= i_ff + CW'(1);
            bgsqr_pkg::ST_DOT_WRITE: begin
               i_ff <= '0;
               sub_init_ff <= 1'b1;
               k_ff <= last_k ? klo_ff : k_ff + CW'(1);
            end
            bgsqr_pkg::ST_SUB_ISSUE: begin
               sub_init_ff <= 1'b0;
               k_ff <= sub_init_ff ? klo_ff : k_ff + CW'(1);
            end
            bgsqr_pkg::ST_SUB_WRITE: begin
               i_ff <= last_i ? '0 : i_ff + CW'(1);
               sub_init_ff <= 1'b1;
            end
            bgsqr_pkg::ST_SQRT_LOAD: begin
               sq_x_ff   <= acc_ff;
               sq_res_ff <= '0;
               sq_bit_ff <= 64'h4000_0000_0000_0000;
               step_ff   <= '0;
            end
            bgsqr_pkg::ST_SQRT_RUN: begin
               if (sq_x_ff >= trial) begin
                  sq_x_ff   <= sq_x_ff - trial;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               step_ff   <= step_ff + 6'd1;
            end
            bgsqr_pkg::ST_NRM_WRITE: begin
               nrm_ff <= nrm_sat;
               i_ff   <= '0;
               if (nrm_sat == '0) flag_ff <= 1'b1;
            end
            bgsqr_pkg::ST_DIV_LOAD: begin
               dv_neg_ff <= qa_rd[31];
               dv_num_ff <= {mag, 16'h0000} + 48'(nrm_ff >> 1);
               dv_rem_ff <= '0;
               step_ff   <= '0;
            end
            bgsqr_pkg::ST_DIV_RUN: begin
               dv_rem_ff <= qbit ? rem_sh - {1'b0, nrm_ff} : rem_sh;
               dv_num_ff <= {dv_num_ff[46:0], qbit};
               step_ff   <= step_ff + 6'd1;
            end
            bgsqr_pkg::ST_DIV_WRITE: i_ff <= i_ff + CW'(1);
            bgsqr_pkg::ST_COL_NEXT: begin
               c_ff <= c_ff + CW'(1);
               if (col_last) b_ff <= c_ff + CW'(1);
            end
            bgsqr_pkg::ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{read_value: '0, status: flag_ff};
            end
            default: begin
            end
         endcase
      end
   end

   assign busy      = (state_ff != bgsqr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Checks on sequencing.
   `BGSQR_ASSERT_NEXT(a_read_busy, clock, reset,
      accept && (req.func == bgsqr_pkg::FUNC_READ_Q || req.func == bgsqr_pkg::FUNC_READ_R),
      busy && !rsp_valid, "read did not hold busy for its memory cycle")
   `BGSQR_ASSERT_NEXT(a_done_rsp, clock, reset,
      state_ff == bgsqr_pkg::ST_DONE, rsp_valid && !busy, "run finished without a result")
   `BGSQR_ASSERT_NOW(a_no_host_write_busy, clock, reset,
      q_we && busy, state_ff == bgsqr_pkg::ST_SUB_WRITE || state_ff == bgsqr_pkg::ST_DIV_WRITE,
      "Q written outside an update step")
   `BGSQR_ASSERT_NOW(a_pipe_drained, clock, reset,
      state_ff == bgsqr_pkg::ST_SQRT_LOAD || state_ff == bgsqr_pkg::ST_DOT_WRITE,
      pipe_empty, "accumulator used before the pipe drained")

endmodule

[rtl/bgsqr_ram.sv]
// Generic synchronous RAM with one write port and one registered read port.
module bgsqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read in the cycle after a write sees the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/tb_block_gram_schmidt_qr.sv]
// Self-checking testbench for the block Gram-Schmidt QR unit.
`timescale 1ns / 1ps

module tb_block_gram_schmidt_qr;

   localparam int DIM         = bgsqr_pkg::MATRIX_SIZE_DEF;
   localparam int BLK         = bgsqr_pkg::BLOCK_COLS_DEF;
   localparam int CELLS       = DIM * DIM;
   localparam int ITEM_TARGET = 1900;
   localparam int IDLE_LIMIT  = 400000;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   bgsqr_pkg::req_type req   = '0;
   logic               busy;
   logic               rsp_valid;
   bgsqr_pkg::rsp_type rsp;

   // Shadow state of the factorization unit.
   logic signed [31:0] q_shadow [CELLS];
   logic signed [31:0] r_shadow [CELLS];
   logic               rank_low = 1'b0;

   bgsqr_pkg::rsp_type expected_words[$];
   int      error_count = 0;
   int      items_sent  = 0;
   int      idle_cycles = 0;
   bit      no_gaps     = 1'b0;

   block_gram_schmidt_qr uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always #10 clock = ~clock;

   // Saturating 64-bit signed addition.
   function automatic longint add_sat(longint a, longint b);
      if (b > 0 && a > I64_MAX - b) return I64_MAX;
      if (b < 0 && a < I64_MIN - b) return I64_MIN;
      return a + b;
   endfunction

   // Rounds a Q32.32 value back to Q16.16 with saturation.
   function automatic logic signed [31:0] round_q16(longint v);
      longint lim;
      longint q;
      lim = longint'(1) <<< 62;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      q = (v + 32768) >>> 16;
      if (q > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (q < -64'sh8000_0000) return 32'sh8000_0000;
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] col_dot(int a, int b);
      longint acc;
      acc = 0;
      for (int i = 0; i < DIM; i++)
         acc = add_sat(acc, longint'(q_shadow[a*DIM+i]) * longint'(q_shadow[b*DIM+i]));
      return round_q16(acc);
   endfunction

   // Removes the projections on columns k0..k1-1 from column j.
   function automatic void remove_proj(int j, int k0, int k1);
      longint acc;
      for (int i = 0; i < DIM; i++) begin
         acc = longint'(q_shadow[j*DIM+i]) * 65536;
         for (int k = k0; k < k1; k++)
            acc = add_sat(acc, -(longint'(q_shadow[k*DIM+i]) * longint'(r_shadow[j*DIM+k])));
         q_shadow[j*DIM+i] = round_q16(acc);
      end
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Computes the column norm into R and scales the column to unit length.
   function automatic void unit_col(int c);
      longint unsigned ssq;
      longint unsigned sq;
      longint unsigned nrm;
      longint unsigned mag;
      longint unsigned quo;
      longint v;
      longint res;
      ssq = 0;
      for (int i = 0; i < DIM; i++) begin
         v = q_shadow[c*DIM+i];
         sq = v * v;
         ssq = (ssq > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : ssq + sq;
      end
      nrm = floor_sqrt(ssq);
      if (nrm > 64'h7FFF_FFFF) nrm = 64'h7FFF_FFFF;
      r_shadow[c*DIM+c] = nrm[31:0];
      if (nrm == 0) begin
         rank_low = 1'b1;
         return;
      end
      for (int i = 0; i < DIM; i++) begin
         v = q_shadow[c*DIM+i];
         mag = ((v < 0) ? -v : v) * 65536;
         quo = (mag + nrm / 2) / nrm;
         if (quo > 64'h8000_0000) quo = 64'h8000_0000;
         res = (v < 0) ? -longint'(quo) : longint'(quo);
         if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
         q_shadow[c*DIM+i] = res[31:0];
      end
   endfunction

   function automatic void factor_shadow();
      int w;
      foreach (r_shadow[i]) r_shadow[i] = '0;
      rank_low = 1'b0;
      for (int b = 0; b < DIM; b += BLK) begin
         w = (DIM - b < BLK) ? DIM - b : BLK;
         if (b > 0) begin
            for (int j = b; j < b + w; j++)
               for (int k = 0; k < b; k++)
                  r_shadow[j*DIM+k] = col_dot(k, j);
            for (int j = b; j < b + w; j++)
               remove_proj(j, 0, b);
         end
         unit_col(b);
         for (int c = b + 1; c < b + w; c++) begin
            for (int k = b; k < c; k++)
               r_shadow[c*DIM+k] = col_dot(k, c);
            remove_proj(c, b, c);
            unit_col(c);
         end
      end
   endfunction

   // Applies one command word to the shadow state and returns the expected answer.
   function automatic bgsqr_pkg::rsp_type predict_word(bgsqr_pkg::req_type it);
      bgsqr_pkg::rsp_type o;
      int idx;
      idx = int'(it.col) * DIM + int'(it.row);
      o.read_value = '0;
      case (it.func)
         bgsqr_pkg::FUNC_WRITE_A: q_shadow[idx] = it.value;
         bgsqr_pkg::FUNC_RUN:     factor_shadow();
         bgsqr_pkg::FUNC_READ_Q:  o.read_value = q_shadow[idx];
         default:                 o.read_value = r_shadow[idx];
      endcase
      o.status = rank_low;
      return o;
   endfunction

   // Predicts accepted words and checks each answer against the oldest expectation.
   always @(posedge clock) begin
      bgsqr_pkg::rsp_type want;
      if (!reset && start && !busy)
         expected_words.push_back(predict_word(req));
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $error("unexpected answer: read_value %0d status %0d", rsp.read_value, rsp.status);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
               error_count++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               error_count++;
            end
         end
      end
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_block_gram_schmidt_qr: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one command word, after a random gap unless no_gaps is set, and waits until it is taken.
   task automatic send_word(bgsqr_pkg::func_type f, int r, int c, logic signed [31:0] v);
      int gap;
      bit taken;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.func  <= f;
      req.row   <= r[3:0];
      req.col   <= c[3:0];
      req.value <= v;
      start     <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      items_sent++;
   endtask

   // Draws an element value of the given flavor.
   function automatic logic signed [31:0] pick_value(int flavor);
      case (flavor)
         0: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         1: return $urandom;
         default: begin
            case ($urandom_range(0, 7))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return bgsqr_pkg::ONE_Q16;
               3: return -bgsqr_pkg::ONE_Q16;
               4: return '0;
               default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            endcase
         end
      endcase
   endfunction

   // Loads a whole matrix; shape 0 random, 1 identity, 2 zero and repeated columns.
   task automatic load_matrix(int shape, int flavor);
      logic signed [31:0] v;
      int zc;
      zc = $urandom_range(0, DIM - 2);
      for (int c = 0; c < DIM; c++)
         for (int r = 0; r < DIM; r++) begin
            case (shape)
               1: v = (r == c) ? bgsqr_pkg::ONE_Q16 : '0;
               2: v = (c == zc) ? '0 : (c == zc + 1) ? q_shadow[(c-1)*DIM+r] :
                      pick_value(flavor);
               default: v = pick_value(flavor);
            endcase
            send_word(bgsqr_pkg::FUNC_WRITE_A, r, c, v);
         end
   endtask

   task automatic read_some(int count);
      for (int n = 0; n < count; n++)
         send_word($urandom_range(0, 1) ? bgsqr_pkg::FUNC_READ_Q : bgsqr_pkg::FUNC_READ_R,
                   $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), $urandom);
   endtask

   task automatic read_diagonal();
      for (int i = 0; i < DIM; i++) send_word(bgsqr_pkg::FUNC_READ_R, i, i, '0);
   endtask

   // Field extremes and reads before any factorization, then a run and reads of the result.
   task automatic test_extremes();
      load_matrix(0, 0);
      send_word(bgsqr_pkg::FUNC_WRITE_A, 0, 0, 32'sh7FFF_FFFF);
      send_word(bgsqr_pkg::FUNC_WRITE_A, 15, 15, 32'sh8000_0000);
      send_word(bgsqr_pkg::FUNC_WRITE_A, 15, 0, -bgsqr_pkg::ONE_Q16);
      send_word(bgsqr_pkg::FUNC_READ_Q, 0, 0, 32'hFFFF_FFFF);
      send_word(bgsqr_pkg::FUNC_READ_Q, 15, 15, '0);
      send_word(bgsqr_pkg::FUNC_READ_Q, 15, 0, '0);
      send_word(bgsqr_pkg::FUNC_READ_R, 0, 0, '0);
      send_word(bgsqr_pkg::FUNC_READ_R, 15, 15, 32'hFFFF_FFFF);
      send_word(bgsqr_pkg::FUNC_RUN, 0, 15, '0);
      read_diagonal();
      send_word(bgsqr_pkg::FUNC_READ_Q, 0, 0, '0);
      send_word(bgsqr_pkg::FUNC_READ_Q, 15, 15, '0);
   endtask

   // The identity factors to itself.
   task automatic test_identity();
      load_matrix(1, 0);
      send_word(bgsqr_pkg::FUNC_RUN, 15, 0, 32'hFFFF_FFFF);
      read_some(20);
   endtask

   // A zero column and a repeated column both give a zero norm.
   task automatic test_rank_deficient();
      load_matrix(2, 0);
      send_word(bgsqr_pkg::FUNC_RUN, 0, 0, '0);
      read_diagonal();
      send_word(bgsqr_pkg::FUNC_WRITE_A, 3, 3, bgsqr_pkg::ONE_Q16);
      send_word(bgsqr_pkg::FUNC_READ_R, 3, 3, '0);
   endtask

   // Full loads or partial rewrites, some reads, a run, then reads of the diagonal and more.
   task automatic test_random();
      int flavor;
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         flavor = $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0) begin
            for (int n = 0; n < 40; n++)
               send_word(bgsqr_pkg::FUNC_WRITE_A, $urandom_range(0, DIM - 1),
                         $urandom_range(0, DIM - 1), pick_value(flavor));
         end else begin
            load_matrix($urandom_range(0, 5) == 0 ? 2 : 0, flavor);
         end
         read_some($urandom_range(5, 20));
         send_word(bgsqr_pkg::FUNC_RUN, $urandom_range(0, DIM - 1),
                   $urandom_range(0, DIM - 1), $urandom);
         read_diagonal();
         read_some($urandom_range(30, 60));
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      // R reads as zero until the first run.
      foreach (r_shadow[i]) r_shadow[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_identity();
      test_rank_deficient();
      test_random();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_block_gram_schmidt_qr: clean");
      end else begin
         $display("tb_block_gram_schmidt_qr: errors");
      end
      $finish;
   end

endmodule
